### rtl/core/lspr_pkg.sv
// Shared types and constants for the LED strip pattern rotator.
package lspr_pkg;

  localparam int unsigned CMD_W      = 1;
  localparam int unsigned PIX_IDX_W  = 6;
  localparam int unsigned COLOR_W    = 24;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned JUMP_W     = 6;
  localparam int unsigned DELAY_W    = 15;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 15;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_WRITE = 1'b0;
  localparam logic [CMD_W-1:0] CMD_DRAW  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_SIZE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_JUMP_DELAY    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_ENABLE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ALT_DELAY     = 3'd4;

  // Move mode codes
  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;

  // Register reset values
  localparam logic [MODE_W-1:0]  RST_MOVE_MODE  = 2'd0;
  localparam logic [JUMP_W-1:0]  RST_JUMP_SIZE  = 6'd1;
  localparam logic [DELAY_W-1:0] RST_JUMP_DELAY = 15'd100;
  localparam logic               RST_ALT_ENABLE = 1'b0;
  localparam logic [DELAY_W-1:0] RST_ALT_DELAY  = 15'd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLIP,
    ST_JUMP,
    ST_SETUP,
    ST_STREAM
  } lspr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic mem_wr;
    logic load_now;
    logic flip_step;
    logic jump_step;
    logic setup;
    logic issue;
  } lspr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic motion_on;
    logic issue_ok;
    logic last_issue;
  } lspr_stat_t;

endpackage

### rtl/core/led_strip_pattern_rotator_top.sv
// Draw sequence: with motion on, a flip step and a jump step come before the setup step;
// each pixel then passes the memory read register and the output register. A pixel write
// does not stall the input; a draw stalls it until the last pixel has been issued.
// Output: one pixel per cycle while the output is not stalled.
// Reset clears registers to their defaults and the pattern valid bits, so the whole
// pattern reads black right after reset; no clearing pass is needed.
module led_strip_pattern_rotator_top #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lspr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lspr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [lspr_pkg::CMD_W-1:0]          cmd_i,
  input  logic [lspr_pkg::PIX_IDX_W-1:0]      pixel_index_i,
  input  logic [lspr_pkg::COLOR_W-1:0]        pixel_color_i,
  input  logic [lspr_pkg::TIME_W-1:0]         now_ms_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lspr_pkg::PIX_IDX_W-1:0]      led_pos_o,
  output logic [lspr_pkg::COLOR_W-1:0]        led_color_o,
  output logic                                last_pixel_o
);

  lspr_pkg::lspr_cmd_t  cmd;
  lspr_pkg::lspr_stat_t stat;

  lspr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  lspr_dpath #(
    .LED_COUNT (LED_COUNT)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_index_i (pixel_index_i),
    .pixel_color_i (pixel_color_i),
    .now_ms_i      (now_ms_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .led_pos_o     (led_pos_o),
    .led_color_o   (led_color_o),
    .last_pixel_o  (last_pixel_o)
  );

endmodule

### rtl/core/lspr_ctrl.sv
// Sequencer for pixel writes and frame draws of the LED strip pattern rotator.
module lspr_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lspr_pkg::CMD_W-1:0]        cmd_i,
  input  lspr_pkg::lspr_stat_t              stat_i,
  output lspr_pkg::lspr_cmd_t               cmd_o
);

  lspr_pkg::lspr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lspr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != lspr_pkg::ST_IDLE);
    case (state_q)
      lspr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == lspr_pkg::CMD_WRITE) begin
            cmd_o.mem_wr = 1'b1;
          end else begin
            cmd_o.load_now = 1'b1;
            state_d = stat_i.motion_on ? lspr_pkg::ST_FLIP : lspr_pkg::ST_SETUP;
          end
        end
      end
      lspr_pkg::ST_FLIP: begin
        cmd_o.flip_step = 1'b1;
        state_d = lspr_pkg::ST_JUMP;
      end
      lspr_pkg::ST_JUMP: begin
        cmd_o.jump_step = 1'b1;
        state_d = lspr_pkg::ST_SETUP;
      end
      lspr_pkg::ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = lspr_pkg::ST_STREAM;
      end
      lspr_pkg::ST_STREAM: begin
        if (stat_i.issue_ok) begin
          cmd_o.issue = 1'b1;
          if (stat_i.last_issue) begin
            state_d = lspr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = lspr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/lspr_dpath.sv
// Registers, motion state, pattern memory and output pipeline of the rotator.
module lspr_dpath #(
  parameter int unsigned LED_COUNT = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lspr_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lspr_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [lspr_pkg::PIX_IDX_W-1:0]      pixel_index_i,
  input  logic [lspr_pkg::COLOR_W-1:0]        pixel_color_i,
  input  logic [lspr_pkg::TIME_W-1:0]         now_ms_i,
  input  lspr_pkg::lspr_cmd_t                 cmd_i,
  output lspr_pkg::lspr_stat_t                stat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [lspr_pkg::PIX_IDX_W-1:0]      led_pos_o,
  output logic [lspr_pkg::COLOR_W-1:0]        led_color_o,
  output logic                                last_pixel_o
);

  localparam int unsigned IDX_W = $clog2(LED_COUNT);
  localparam int unsigned RED_W = lspr_pkg::JUMP_W + 7;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W:0]   COUNT_X  = (IDX_W+1)'(LED_COUNT);

  // Configuration registers
  logic [lspr_pkg::MODE_W-1:0]  move_mode_q;
  logic [lspr_pkg::JUMP_W-1:0]  jump_size_q;
  logic [lspr_pkg::DELAY_W-1:0] jump_delay_q;
  logic                         alt_en_q;
  logic [lspr_pkg::DELAY_W-1:0] alt_delay_q;

  // Motion state
  logic [IDX_W-1:0]            offset_q, offset_d;
  logic                        back_q;
  logic [lspr_pkg::TIME_W-1:0] last_jump_q, last_flip_q, now_q;

  // Pattern memory with per-entry valid bits; an unwritten entry reads black
  logic [lspr_pkg::COLOR_W-1:0] mem_q [LED_COUNT];
  logic [LED_COUNT-1:0]         filled_q;
  logic                         wr_ok;

  // Stream counters and pipeline
  logic [IDX_W-1:0]             cnt_q, src_q, start_d;
  logic                         s1_valid_q, s1_last_q, s1_ok_q;
  logic [IDX_W-1:0]             s1_idx_q;
  logic [lspr_pkg::COLOR_W-1:0] rd_data_q;
  logic                         out_valid_q, out_last_q;
  logic [IDX_W-1:0]             out_idx_q;
  logic [lspr_pkg::COLOR_W-1:0] out_color_q;
  logic                         out_adv;

  logic                         flip_due, jump_due;
  logic [RED_W-1:0]             rem;
  logic [IDX_W-1:0]             step;
  logic [IDX_W:0]               sum_fwd, sum_bwd, sum_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_mode_q  <= lspr_pkg::RST_MOVE_MODE;
      jump_size_q  <= lspr_pkg::RST_JUMP_SIZE;
      jump_delay_q <= lspr_pkg::RST_JUMP_DELAY;
      alt_en_q     <= lspr_pkg::RST_ALT_ENABLE;
      alt_delay_q  <= lspr_pkg::RST_ALT_DELAY;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lspr_pkg::REG_MOVE_MODE:  move_mode_q  <= cfg_data_i[lspr_pkg::MODE_W-1:0];
        lspr_pkg::REG_JUMP_SIZE:  jump_size_q  <= cfg_data_i[lspr_pkg::JUMP_W-1:0];
        lspr_pkg::REG_JUMP_DELAY: jump_delay_q <= cfg_data_i;
        lspr_pkg::REG_ALT_ENABLE: alt_en_q     <= cfg_data_i[0];
        lspr_pkg::REG_ALT_DELAY:  alt_delay_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign flip_due = alt_en_q &&
                    ((now_q - last_flip_q) >= {{(lspr_pkg::TIME_W-lspr_pkg::DELAY_W){1'b0}},
                                               alt_delay_q});
  assign jump_due = (now_q - last_jump_q) >= {{(lspr_pkg::TIME_W-lspr_pkg::DELAY_W){1'b0}},
                                              jump_delay_q};

  // Reduce jump size modulo strip length by shifted compare and subtract
  always_comb begin
    rem = RED_W'(jump_size_q);
    for (int k = lspr_pkg::JUMP_W - 1; k >= 0; k--) begin
      if (rem >= (RED_W'(LED_COUNT) << k)) begin
        rem = rem - (RED_W'(LED_COUNT) << k);
      end
    end
    step = rem[IDX_W-1:0];
  end

  always_comb begin
    sum_fwd  = {1'b0, offset_q} + {1'b0, step};
    sum_bwd  = {1'b0, offset_q} + COUNT_X - {1'b0, step};
    sum_sel  = back_q ? sum_bwd : sum_fwd;
    offset_d = (sum_sel >= COUNT_X) ? IDX_W'(sum_sel - COUNT_X) : sum_sel[IDX_W-1:0];
    // first source entry is (0 - offset) mod N
    start_d  = (offset_q == '0) ? '0 : IDX_W'(COUNT_X - {1'b0, offset_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      back_q      <= 1'b0;
      last_jump_q <= '0;
      last_flip_q <= '0;
    end else begin
      if (cfg_we_i && cfg_index_i == lspr_pkg::REG_MOVE_MODE) begin
        back_q <= cfg_data_i[1];
      end else if (cmd_i.flip_step && flip_due) begin
        back_q      <= !back_q;
        last_flip_q <= now_q;
      end
      if (cmd_i.jump_step && jump_due) begin
        offset_q    <= offset_d;
        last_jump_q <= now_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      now_q <= now_ms_i;
    end
  end

  assign wr_ok = cmd_i.mem_wr && ({1'b0, pixel_index_i} < 7'(LED_COUNT));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[pixel_index_i[IDX_W-1:0]] <= pixel_color_i;
    end
    if (cmd_i.issue) begin
      rd_data_q <= mem_q[src_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= '0;
    end else if (wr_ok) begin
      filled_q[pixel_index_i[IDX_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      cnt_q <= '0;
      src_q <= (move_mode_q != lspr_pkg::MODE_OFF) ? start_d : '0;
    end else if (cmd_i.issue) begin
      cnt_q <= cnt_q + 1'b1;
      src_q <= (src_q == LAST_IDX) ? '0 : src_q + 1'b1;
    end
  end

  assign out_adv = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.issue) begin
        s1_valid_q <= 1'b1;
      end else if (out_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s1_idx_q  <= cnt_q;
      s1_last_q <= (cnt_q == LAST_IDX);
      s1_ok_q   <= filled_q[src_q];
    end
    if (out_adv && s1_valid_q) begin
      out_idx_q   <= s1_idx_q;
      out_last_q  <= s1_last_q;
      out_color_q <= s1_ok_q ? rd_data_q : '0;
    end
  end

  assign stat_o.motion_on  = (move_mode_q != lspr_pkg::MODE_OFF);
  assign stat_o.issue_ok   = !s1_valid_q || out_adv;
  assign stat_o.last_issue = (cnt_q == LAST_IDX);

  assign out_valid_o  = out_valid_q;
  assign led_pos_o    = lspr_pkg::PIX_IDX_W'(out_idx_q);
  assign led_color_o  = out_color_q;
  assign last_pixel_o = out_last_q;

endmodule

### tb/led_strip_pattern_rotator_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the LED strip pattern rotator: pattern writes, rotated frames.
module led_strip_pattern_rotator_top_tb;

  localparam int unsigned STRIP_LEDS      = 32;
  localparam int unsigned SLOT_W          = $clog2(STRIP_LEDS);
  localparam int unsigned RESET_CYCLES    = 7;
  localparam int unsigned SETTLE_CYCLES   = STRIP_LEDS + 8;
  localparam int unsigned STUCK_LIMIT     = 5000;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam int unsigned WORDS_PER_PHASE = 32;
  localparam int unsigned TOP_PIXEL_INDEX = 2**lspr_pkg::PIX_IDX_W - 1;

  localparam logic [lspr_pkg::CFG_DATA_W-1:0] MODE_NONE       = 15'd0;
  localparam logic [lspr_pkg::CFG_DATA_W-1:0] MODE_FWD        = 15'd1;
  localparam logic [lspr_pkg::CFG_DATA_W-1:0] MODE_BACK       = 15'd2;
  localparam logic [lspr_pkg::CFG_DATA_W-1:0] MODE_BACK_ALIAS = 15'd3;
  localparam logic [lspr_pkg::CFG_IDX_W-1:0]  REG_SPARE_LO    = lspr_pkg::REG_ALT_DELAY + 1'b1;
  localparam logic [lspr_pkg::CFG_IDX_W-1:0]  REG_SPARE_HI    = '1;

  typedef struct packed {
    logic [lspr_pkg::CMD_W-1:0]     cmd;
    logic [lspr_pkg::PIX_IDX_W-1:0] pixel_index;
    logic [lspr_pkg::COLOR_W-1:0]   pixel_color;
    logic [lspr_pkg::TIME_W-1:0]    now_ms;
  } rot_word_t;

  typedef struct packed {
    logic [lspr_pkg::PIX_IDX_W-1:0] led_pos;
    logic [lspr_pkg::COLOR_W-1:0]   led_color;
    logic                           last_pixel;
  } led_pixel_t;

  logic                            clk_i         = 1'b0;
  logic                            rst_ni        = 1'b0;
  logic                            cfg_we_i      = 1'b0;
  logic [lspr_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [lspr_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                            in_valid_i    = 1'b0;
  logic                            in_stall_o;
  logic [lspr_pkg::CMD_W-1:0]      cmd_i         = lspr_pkg::CMD_WRITE;
  logic [lspr_pkg::PIX_IDX_W-1:0]  pixel_index_i = '0;
  logic [lspr_pkg::COLOR_W-1:0]    pixel_color_i = '0;
  logic [lspr_pkg::TIME_W-1:0]     now_ms_i      = '0;
  logic                            out_valid_o;
  logic                            out_stall_i   = 1'b0;
  logic [lspr_pkg::PIX_IDX_W-1:0]  led_pos_o;
  logic [lspr_pkg::COLOR_W-1:0]    led_color_o;
  logic                            last_pixel_o;

  rot_word_t  words_to_send[$];
  led_pixel_t frame_pixels_due[$];

  // Shadow copy of the block's registers and motion state.
  logic [lspr_pkg::MODE_W-1:0]  reg_mode       = lspr_pkg::RST_MOVE_MODE;
  logic [lspr_pkg::JUMP_W-1:0]  reg_jump       = lspr_pkg::RST_JUMP_SIZE;
  logic [lspr_pkg::DELAY_W-1:0] reg_jump_delay = lspr_pkg::RST_JUMP_DELAY;
  logic                         reg_alt_en     = lspr_pkg::RST_ALT_ENABLE;
  logic [lspr_pkg::DELAY_W-1:0] reg_alt_delay  = lspr_pkg::RST_ALT_DELAY;
  logic [lspr_pkg::COLOR_W-1:0] shadow_pattern [STRIP_LEDS] = '{default: '0};
  int unsigned                  shadow_offset  = 0;
  logic                         shadow_backwards = 1'b0;
  logic [lspr_pkg::TIME_W-1:0]  shadow_last_jump = '0;
  logic [lspr_pkg::TIME_W-1:0]  shadow_last_flip = '0;

  int unsigned sender_idle_pct    = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned mismatch_count     = 0;
  int unsigned stuck_cycles       = 0;
  logic [lspr_pkg::TIME_W-1:0] ms_clock = '0;

  led_strip_pattern_rotator_top #(
    .LED_COUNT(STRIP_LEDS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .cmd_i         (cmd_i),
    .pixel_index_i (pixel_index_i),
    .pixel_color_i (pixel_color_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .led_pos_o     (led_pos_o),
    .led_color_o   (led_color_o),
    .last_pixel_o  (last_pixel_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Apply one accepted word to the shadow state; a draw queues the whole frame.
  function automatic void absorb_word(input rot_word_t w);
    int unsigned shift;
    int unsigned step;
    led_pixel_t  px;
    if (w.cmd == lspr_pkg::CMD_WRITE) begin
      if (w.pixel_index < STRIP_LEDS)
        shadow_pattern[w.pixel_index[SLOT_W-1:0]] = w.pixel_color;
      return;
    end
    shift = 0;
    if (reg_mode != lspr_pkg::MODE_OFF) begin
      if (reg_alt_en && (w.now_ms - shadow_last_flip) >= reg_alt_delay) begin
        shadow_backwards = !shadow_backwards;
        shadow_last_flip = w.now_ms;
      end
      if ((w.now_ms - shadow_last_jump) >= reg_jump_delay) begin
        step = reg_jump % STRIP_LEDS;
        if (shadow_backwards) shadow_offset = (shadow_offset + STRIP_LEDS - step) % STRIP_LEDS;
        else shadow_offset = (shadow_offset + step) % STRIP_LEDS;
        shadow_last_jump = w.now_ms;
      end
      shift = shadow_offset;
    end
    for (int unsigned j = 0; j < STRIP_LEDS; j++) begin
      px.led_pos    = lspr_pkg::PIX_IDX_W'(j);
      px.led_color  = shadow_pattern[SLOT_W'((j + STRIP_LEDS - shift) % STRIP_LEDS)];
      px.last_pixel = (j == STRIP_LEDS - 1);
      frame_pixels_due.push_back(px);
    end
  endfunction

  function automatic void queue_pixel(input int unsigned idx,
                                      input logic [lspr_pkg::COLOR_W-1:0] color);
    rot_word_t w;
    w.cmd         = lspr_pkg::CMD_WRITE;
    w.pixel_index = lspr_pkg::PIX_IDX_W'(idx);
    w.pixel_color = color;
    w.now_ms      = $urandom();
    words_to_send.push_back(w);
  endfunction

  function automatic void queue_draw(input logic [lspr_pkg::TIME_W-1:0] stamp);
    rot_word_t w;
    w.cmd         = lspr_pkg::CMD_DRAW;
    w.pixel_index = lspr_pkg::PIX_IDX_W'($urandom());
    w.pixel_color = lspr_pkg::COLOR_W'($urandom());
    w.now_ms      = stamp;
    words_to_send.push_back(w);
  endfunction

  // Keep the low bits, fill the rest of the write data with junk the block must mask.
  function automatic logic [lspr_pkg::CFG_DATA_W-1:0] with_junk(
      input logic [lspr_pkg::CFG_DATA_W-1:0] v,
      input int unsigned keep);
    logic [lspr_pkg::CFG_DATA_W-1:0] m;
    m = lspr_pkg::CFG_DATA_W'((1 << keep) - 1);
    return (lspr_pkg::CFG_DATA_W'($urandom()) & ~m) | (v & m);
  endfunction

  task automatic wait_until_idle();
    do @(negedge clk_i);
    while (words_to_send.size() != 0 || in_valid_i || frame_pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic program_reg(input logic [lspr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lspr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    case (idx)
      lspr_pkg::REG_MOVE_MODE: begin
        reg_mode = data[lspr_pkg::MODE_W-1:0];
        // upper mode bit selects backwards; the write reloads direction
        shadow_backwards = reg_mode[lspr_pkg::MODE_W-1];
      end
      lspr_pkg::REG_JUMP_SIZE:  reg_jump       = data[lspr_pkg::JUMP_W-1:0];
      lspr_pkg::REG_JUMP_DELAY: reg_jump_delay = data[lspr_pkg::DELAY_W-1:0];
      lspr_pkg::REG_ALT_ENABLE: reg_alt_en     = data[0];
      lspr_pkg::REG_ALT_DELAY:  reg_alt_delay  = data[lspr_pkg::DELAY_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_motion(input logic [lspr_pkg::CFG_DATA_W-1:0] mode_d,
                            input logic [lspr_pkg::CFG_DATA_W-1:0] jump_d,
                            input logic [lspr_pkg::CFG_DATA_W-1:0] jdelay_d,
                            input logic [lspr_pkg::CFG_DATA_W-1:0] alt_d,
                            input logic [lspr_pkg::CFG_DATA_W-1:0] adelay_d);
    wait_until_idle();
    program_reg(lspr_pkg::REG_MOVE_MODE, mode_d);
    program_reg(lspr_pkg::REG_JUMP_SIZE, jump_d);
    program_reg(lspr_pkg::REG_JUMP_DELAY, jdelay_d);
    program_reg(lspr_pkg::REG_ALT_ENABLE, alt_d);
    program_reg(lspr_pkg::REG_ALT_DELAY, adelay_d);
    // unmapped index: must not disturb anything
    program_reg(lspr_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                lspr_pkg::CFG_DATA_W'($urandom()));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: present the next word once the current one is taken.
  always @(posedge clk_i) begin
    rot_word_t nxt;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        absorb_word({cmd_i, pixel_index_i, pixel_color_i, now_ms_i});
      if (!in_valid_i || !in_stall_o) begin
        if (words_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = words_to_send.pop_front();
          in_valid_i    <= 1'b1;
          cmd_i         <= nxt.cmd;
          pixel_index_i <= nxt.pixel_index;
          pixel_color_i <= nxt.pixel_color;
          now_ms_i      <= nxt.now_ms;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted pixel against the oldest one due.
  always @(posedge clk_i) begin
    led_pixel_t due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (frame_pixels_due.size() == 0) begin
          $error("pixel %0d arrived with none expected", led_pos_o);
          mismatch_count++;
        end else begin
          due = frame_pixels_due.pop_front();
          if (led_pos_o !== due.led_pos) begin
            $error("led_pos: expected %0d, got %0d", due.led_pos, led_pos_o);
            mismatch_count++;
          end
          if (led_color_o !== due.led_color) begin
            $error("led_color: expected %06h, got %06h", due.led_color, led_color_o);
            mismatch_count++;
          end
          if (last_pixel_o !== due.last_pixel) begin
            $error("last_pixel: expected %0b, got %0b", due.last_pixel, last_pixel_o);
            mismatch_count++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Watchdog: give up when neither side moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned span;
    int unsigned idx;
    logic [lspr_pkg::COLOR_W-1:0] color;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: black after reset, extremes, dropped writes, motion corner cases.
    queue_draw(32'd0);
    queue_pixel(0, 24'hFFFFFF);
    queue_pixel(1, 24'hFF0000);
    queue_pixel(2, 24'h00FF00);
    queue_pixel(STRIP_LEDS - 1, 24'h0000FF);
    queue_pixel(STRIP_LEDS, 24'h5A5A5A);
    queue_pixel(TOP_PIXEL_INDEX, 24'hA5A5A5);
    queue_draw(32'hFFFF_FFFF);
    // zero delays: jump on every draw, even with the same timestamp
    set_motion(MODE_FWD, 15'd1, 15'd0, 15'd0, 15'd0);
    queue_draw(32'd0);
    queue_draw(32'd0);
    queue_draw(32'd7);
    // mode three acts as backwards; full jump size wraps; timestamps wrap
    set_motion(MODE_BACK_ALIAS, 15'd63, 15'd32767, 15'd1, 15'd0);
    queue_draw(32'd32767);
    queue_draw(32'hFFFF_FFFF);
    queue_draw(32'd16);
    set_motion(MODE_BACK, 15'd32, 15'd1, 15'd1, 15'd32767);
    queue_pixel(3, 24'h123456);
    queue_draw(32'd100);
    queue_draw(32'd101);
    // motion off: offset and times frozen, frame unrotated
    set_motion(MODE_NONE, 15'd5, 15'd0, 15'd1, 15'd0);
    queue_draw(32'd5000);
    set_motion(MODE_FWD, 15'd5, 15'd0, 15'd0, 15'd1000);
    queue_draw(32'd5001);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        set_motion(MODE_FWD, 15'd63, 15'd32767, 15'd1, 15'd32767);
        span = 40000;
      end else if (p == 1) begin
        set_motion(MODE_BACK_ALIAS, 15'd0, 15'd0, 15'd1, 15'd0);
        span = 4;
      end else begin
        set_motion(with_junk(lspr_pkg::CFG_DATA_W'($urandom_range(MODE_BACK_ALIAS)),
                             lspr_pkg::MODE_W),
                   with_junk(lspr_pkg::CFG_DATA_W'($urandom_range(63)), lspr_pkg::JUMP_W),
                   lspr_pkg::CFG_DATA_W'($urandom_range(60)),
                   with_junk(lspr_pkg::CFG_DATA_W'($urandom_range(1)), 1),
                   lspr_pkg::CFG_DATA_W'($urandom_range(150)));
        span = $urandom_range(8, 100);
      end
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 85; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 85; end
        default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
      endcase
      for (int k = 0; k < WORDS_PER_PHASE; k++) begin
        if ($urandom_range(99) < 55) begin
          if ($urandom_range(9) == 0) idx = $urandom_range(STRIP_LEDS, TOP_PIXEL_INDEX);
          else idx = $urandom_range(STRIP_LEDS - 1);
          case ($urandom_range(5))
            0: color = '0;
            1: color = '1;
            default: color = lspr_pkg::COLOR_W'($urandom());
          endcase
          queue_pixel(idx, color);
        end else begin
          case ($urandom_range(9))
            0: ms_clock = $urandom();
            1: ms_clock += $urandom_range(40000);
            2: ;
            default: ms_clock += $urandom_range(span);
          endcase
          queue_draw(ms_clock);
        end
      end
    end

    wait_until_idle();
    if (mismatch_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### filelist.f
rtl/core/lspr_pkg.sv
rtl/core/lspr_ctrl.sv
rtl/core/lspr_dpath.sv
rtl/core/led_strip_pattern_rotator_top.sv
tb/led_strip_pattern_rotator_top_tb.sv
